@@ src/mura_pkg.sv @@
package mura_pkg;

	localparam int NUM_RES    = 4;
	localparam int NUM_PROC   = 16;
	localparam int WAIT_DEPTH = 16;
	localparam int RES_W      = 2;
	localparam int PROC_W     = 4;
	localparam int WPTR_W     = 4;
	localparam int WCNT_W     = 5;
	localparam int HELD_W     = RES_W + PROC_W;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_BLOCKED   = 3'd1,
		ST_REQERR    = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_EXCEEDED  = 3'd4,
		ST_UNBLOCKED = 3'd5
	} status_t;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef struct packed {
		logic       func;
		logic [3:0] proc_id;
		logic [1:0] res_id;
		logic [3:0] units;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] who;
		logic [3:0] count;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_WREAD,
		S_WCHECK,
		S_OUT
	} state_t;

endpackage

@@ src/mura_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mura_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ src/multi_unit_resource_allocator.sv @@
// Multi-unit resource allocator: counting semaphore per resource with a
// FIFO wait queue per resource.
// Input channel (in_valid/in_stall/in_data): one word is a request or a
// release of units of one resource by one process. in_stall is high while
// an item is being worked on and during the post-reset clear.
// Output channel (out_valid/out_stall/out_data): one result word per
// grant, block, error, release or unblocked waiter; last marks the final
// word of an item. A stalled word holds until taken, and the sequencer
// waits in place (input stays stalled) until the output register frees.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): sets a
// resource's total and refills its free units. cfg_ready is high only
// while idle.
// Sequence: an item is taken in IDLE, READ reads the held-count and
// queue-head RAMs, EXEC decides and writes the result word to the output
// register; the next input word is taken only back in IDLE. Each
// unblocked waiter passes WREAD (queue entry capture, held-count read),
// WCHECK (grant) and OUT (its word). The registered RAM reads set this order.
// Reset: totals 1,2,3,4, free units equal to totals, queues empty. The
// held-count table is cleared by a sweep over its 64 entries after
// reset, during which no item is accepted.
module multi_unit_resource_allocator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mura_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mura_pkg::out_word_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [3:0]           cfg_data
);
	mura_pkg::state_t st_q, st_d;

	logic [3:0] total_q [mura_pkg::NUM_RES];
	logic [3:0] free_q  [mura_pkg::NUM_RES];
	logic [mura_pkg::WPTR_W-1:0] head_q [mura_pkg::NUM_RES];
	logic [mura_pkg::WCNT_W-1:0] wcnt_q [mura_pkg::NUM_RES];

	mura_pkg::in_word_t item_q;
	mura_pkg::out_word_t obuf_q, word_d;
	logic ovalid_q;
	logic [mura_pkg::HELD_W:0] clr_q;
	logic clearing;
	logic [3:0] wproc_q, wneed_q;

	// held-count RAM: {proc, res} -> units held
	logic                        h_we;
	logic [mura_pkg::HELD_W-1:0] h_waddr, h_raddr;
	logic [3:0]                  h_wdata, h_rdata;
	// wait queue RAM: {res, slot} -> {proc, need}
	logic                        q_we;
	logic [mura_pkg::RES_W+mura_pkg::WPTR_W-1:0] q_waddr, q_raddr;
	logic [7:0]                  q_wdata, q_rdata;

	logic [1:0] r;
	logic [3:0] tot, fr;
	logic [4:0] sum;
	logic [mura_pkg::WPTR_W-1:0] hd, tail_slot;
	logic [mura_pkg::WCNT_W-1:0] wc;
	logic [3:0] rel, fsat;
	logic [4:0] fsum;
	logic [4:0] hsum;
	logic req_err, req_wait, q_full, req_block, req_grant;
	logic wake_first, wake_next, emit;

	mura_ram #(.DEPTH(mura_pkg::NUM_PROC * mura_pkg::NUM_RES), .WIDTH(4)) u_held (
		.clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	mura_ram #(.DEPTH(mura_pkg::NUM_RES * mura_pkg::WAIT_DEPTH), .WIDTH(8)) u_wait (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata));

	assign clearing  = !clr_q[mura_pkg::HELD_W];
	assign in_stall  = (st_q != mura_pkg::S_IDLE) || clearing;
	assign cfg_ready = (st_q == mura_pkg::S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

	assign r    = item_q.res_id;
	assign tot  = total_q[r];
	assign fr   = free_q[r];
	assign hd   = head_q[r];
	assign wc   = wcnt_q[r];
	assign sum  = {1'b0, h_rdata} + {1'b0, item_q.units};
	assign rel  = (item_q.units < h_rdata) ? item_q.units : h_rdata;
	assign fsum = {1'b0, fr} + {1'b0, rel};
	assign fsat = fsum[4] ? 4'd15 : fsum[3:0];
	assign hsum = {1'b0, h_rdata} + {1'b0, wneed_q};
	assign tail_slot = hd + wc[mura_pkg::WPTR_W-1:0];

	// request decision
	assign req_err   = (item_q.units > tot) || (sum > {1'b0, tot});
	assign req_wait  = (item_q.units > fr) || (wc != '0);
	assign q_full    = (wc >= 5'(mura_pkg::WAIT_DEPTH));
	assign req_block = !req_err && req_wait && !q_full;
	assign req_grant = !req_err && !req_wait;

	// q_rdata holds the current head entry of the item's resource
	assign wake_first = (wc != '0) && (q_rdata[3:0] <= fsat);
	assign wake_next  = (wc != '0) && (q_rdata[3:0] <= fr);

	// a word leaves the sequencer once the output register is free
	assign emit = ((st_q == mura_pkg::S_EXEC) || (st_q == mura_pkg::S_OUT)) &&
		(!ovalid_q || !out_stall);

	always_comb begin
		word_d.status = mura_pkg::ST_REQERR;
		word_d.who    = item_q.proc_id;
		word_d.count  = 4'd0;
		word_d.last   = 1'b1;
		if (st_q == mura_pkg::S_OUT) begin
			word_d.status = mura_pkg::ST_UNBLOCKED;
			word_d.who    = wproc_q;
			word_d.count  = wneed_q;
			word_d.last   = !wake_next;
		end else if (item_q.func == mura_pkg::FUNC_RELEASE) begin
			word_d.status = (item_q.units > h_rdata) ?
				mura_pkg::ST_EXCEEDED : mura_pkg::ST_RELEASED;
			word_d.count  = rel;
			word_d.last   = !wake_first;
		end else if (req_block) begin
			word_d.status = mura_pkg::ST_BLOCKED;
			word_d.count  = item_q.units;
		end else if (req_grant) begin
			word_d.status = mura_pkg::ST_GRANTED;
			word_d.count  = item_q.units;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			mura_pkg::S_IDLE:   if (in_valid && !clearing) st_d = mura_pkg::S_READ;
			mura_pkg::S_READ:   st_d = mura_pkg::S_EXEC;
			mura_pkg::S_EXEC: begin
				if (emit) begin
					if (item_q.func == mura_pkg::FUNC_RELEASE && wake_first)
						st_d = mura_pkg::S_WREAD;
					else
						st_d = mura_pkg::S_IDLE;
				end
			end
			mura_pkg::S_WREAD:  st_d = mura_pkg::S_WCHECK;
			mura_pkg::S_WCHECK: st_d = mura_pkg::S_OUT;
			mura_pkg::S_OUT: begin
				if (emit) begin
					if (wake_next) st_d = mura_pkg::S_WREAD;
					else st_d = mura_pkg::S_IDLE;
				end
			end
			default: st_d = mura_pkg::S_IDLE;
		endcase
	end

	// RAM ports: WREAD reads the waiter's held count, WCHECK prefetches
	// the entry behind the head
	always_comb begin
		h_raddr = {item_q.proc_id, r};
		q_raddr = {r, hd};
		h_we    = 1'b0;
		h_waddr = {item_q.proc_id, r};
		h_wdata = '0;
		q_we    = (st_q == mura_pkg::S_EXEC) && emit &&
			(item_q.func == mura_pkg::FUNC_REQUEST) && req_block;
		q_waddr = {r, tail_slot};
		q_wdata = {item_q.proc_id, item_q.units};
		case (st_q)
			mura_pkg::S_WREAD:  h_raddr = {q_rdata[7:4], r};
			mura_pkg::S_WCHECK: q_raddr = {r, hd + 1'b1};
			default: ;
		endcase
		if (clearing) begin
			h_we    = 1'b1;
			h_waddr = clr_q[mura_pkg::HELD_W-1:0];
		end else if (st_q == mura_pkg::S_EXEC && emit) begin
			if (item_q.func == mura_pkg::FUNC_REQUEST) begin
				h_we    = req_grant;
				h_wdata = sum[3:0];
			end else begin
				h_we    = 1'b1;
				h_wdata = h_rdata - rel;
			end
		end else if (st_q == mura_pkg::S_WCHECK) begin
			h_we    = 1'b1;
			h_waddr = {wproc_q, r};
			h_wdata = hsum[4] ? 4'd15 : hsum[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= mura_pkg::S_IDLE;
			ovalid_q <= 1'b0;
			obuf_q   <= '0;
			item_q   <= '0;
			clr_q    <= '0;
			wproc_q  <= '0;
			wneed_q  <= '0;
			for (int i = 0; i < mura_pkg::NUM_RES; i++) begin
				total_q[i] <= 4'(i + 1);
				free_q[i]  <= 4'(i + 1);
				head_q[i]  <= '0;
				wcnt_q[i]  <= '0;
			end
		end else begin
			st_q     <= st_d;
			ovalid_q <= emit || (ovalid_q && out_stall);
			if (emit) obuf_q <= word_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (st_q == mura_pkg::S_IDLE && in_valid && !clearing) item_q <= in_data;
			if (st_q == mura_pkg::S_WREAD) begin
				wproc_q <= q_rdata[7:4];
				wneed_q <= q_rdata[3:0];
			end
			// config only lands while idle, so it never meets an update below
			if (cfg_valid && cfg_ready) begin
				total_q[cfg_index] <= cfg_data;
				free_q[cfg_index]  <= cfg_data;
			end else if (st_q == mura_pkg::S_EXEC && emit) begin
				if (item_q.func == mura_pkg::FUNC_REQUEST) begin
					if (req_block)
						wcnt_q[r] <= wc + 1'b1;
					else if (req_grant)
						free_q[r] <= fr - item_q.units;
				end else begin
					free_q[r] <= fsat;
				end
			end else if (st_q == mura_pkg::S_WCHECK) begin
				// waiter granted: need already checked against free units
				free_q[r] <= fr - wneed_q;
				head_q[r] <= hd + 1'b1;
				wcnt_q[r] <= wc - 1'b1;
			end
		end
	end
endmodule

@@ sim/mura_checker.sv @@
module mura_checker
	import mura_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_word_t   in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_word_t  out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	output int         failures,
	output int         pending,
	output int         words_seen,
	output int         waiters_woken
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [3:0] total [NUM_RES];
	logic [3:0] free_cnt [NUM_RES];
	logic [3:0] held [NUM_PROC][NUM_RES];
	logic [3:0] q_proc [NUM_RES][WAIT_DEPTH];
	logic [3:0] q_need [NUM_RES][WAIT_DEPTH];
	int         q_head [NUM_RES];
	int         q_cnt [NUM_RES];
	out_word_t  due_words [$];

	function automatic void post(status_t st, logic [3:0] who, logic [3:0] cnt);
		out_word_t w;
		w.status = st;
		w.who    = who;
		w.count  = cnt;
		w.last   = 1'b0;
		due_words = {due_words, w};
	endfunction

	function automatic void allocate(in_word_t w);
		int         r;
		int         p;
		int         slot;
		logic [4:0] sum;
		logic [3:0] rel;
		logic [3:0] need;
		logic [3:0] wp;
		out_word_t  tail;
		r = w.res_id;
		p = w.proc_id;
		if (w.func == FUNC_REQUEST) begin
			sum = held[p][r] + w.units;
			if (w.units > total[r] || sum > total[r]) begin
				post(ST_REQERR, w.proc_id, 4'd0);
			end else if (w.units > free_cnt[r] || q_cnt[r] != 0) begin
				if (q_cnt[r] >= WAIT_DEPTH) begin
					post(ST_REQERR, w.proc_id, 4'd0);
				end else begin
					slot = (q_head[r] + q_cnt[r]) % WAIT_DEPTH;
					q_proc[r][slot] = w.proc_id;
					q_need[r][slot] = w.units;
					q_cnt[r]++;
					post(ST_BLOCKED, w.proc_id, w.units);
				end
			end else begin
				free_cnt[r] = free_cnt[r] - w.units;
				held[p][r]  = sum[3:0];
				post(ST_GRANTED, w.proc_id, w.units);
			end
		end else begin
			rel = (w.units < held[p][r]) ? w.units : held[p][r];
			sum = free_cnt[r] + rel;
			held[p][r]  = held[p][r] - rel;
			free_cnt[r] = (sum > 15) ? 4'd15 : sum[3:0];
			post((w.units > rel) ? ST_EXCEEDED : ST_RELEASED, w.proc_id, rel);
			// wake waiters from the head while free units cover them
			while (q_cnt[r] != 0) begin
				need = q_need[r][q_head[r]];
				wp   = q_proc[r][q_head[r]];
				if (need > free_cnt[r])
					break;
				free_cnt[r] = free_cnt[r] - need;
				sum = held[wp][r] + need;
				held[wp][r] = (sum > 15) ? 4'd15 : sum[3:0];
				q_head[r] = (q_head[r] + 1) % WAIT_DEPTH;
				q_cnt[r]--;
				post(ST_UNBLOCKED, wp, need);
			end
		end
		tail = due_words[$];
		tail.last = 1'b1;
		due_words[$] = tail;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			for (int r = 0; r < NUM_RES; r++) begin
				total[r]    = 4'(r + 1);
				free_cnt[r] = 4'(r + 1);
				q_head[r]   = 0;
				q_cnt[r]    = 0;
				for (int p = 0; p < NUM_PROC; p++)
					held[p][r] = 4'd0;
			end
			due_words.delete();
			failures      = 0;
			pending       = 0;
			words_seen    = 0;
			waiters_woken = 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (out_data.status == ST_UNBLOCKED)
					waiters_woken++;
				if (due_words.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%t unexpected word: status %0d who %0d count %0d last %0d",
							$realtime, out_data.status, out_data.who, out_data.count,
							out_data.last);
				end else begin
					exp_w = due_words[0];
					due_words.delete(0);
					if (exp_w.status !== out_data.status || exp_w.who !== out_data.who ||
						exp_w.count !== out_data.count || exp_w.last !== out_data.last) begin
						failures++;
						if (failures <= 10)
							$display("%t mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, exp_w.status, exp_w.who, exp_w.count, exp_w.last,
								out_data.status, out_data.who, out_data.count, out_data.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				total[cfg_index]    = cfg_data;
				free_cnt[cfg_index] = cfg_data;
			end
			if (in_valid && !in_stall)
				allocate(in_data);
			pending = due_words.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mura_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_CALLS = 22;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	int failures, pending, words_seen, waiters_woken;
	int cycles = 0;
	int calls = 0;
	bit smooth = 1'b0;       // no idling on either side
	int hold_asks = 0;       // long receiver hold-offs requested
	int hold_done = 0;
	logic [3:0] tot [NUM_RES];

	multi_unit_resource_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mura_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending),
		.words_seen(words_seen), .waiters_woken(waiters_woken)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stall, mostly short, a few long; the long hold-off is
	// counted here so the block backs up while the sender keeps going
	initial begin
		int hold_left;
		int pick;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (hold_asks != hold_done) begin
				hold_done++;
				out_stall = 1'b1;
				hold_left = 300;
			end else if (smooth) begin
				out_stall = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					out_stall = 1'b0;
				end else if (pick < 97) begin
					out_stall = 1'b1;
					hold_left = $urandom_range(0, 3);
				end else begin
					out_stall = 1'b1;
					hold_left = $urandom_range(15, 40);
				end
			end
		end
	end

	function automatic in_word_t mk(logic f, int p, int r, int u);
		in_word_t w;
		w.func    = f;
		w.proc_id = 4'(p);
		w.res_id  = 2'(r);
		w.units   = 4'(u);
		return w;
	endfunction

	// called at a falling edge; leaves valid high after the word is taken
	task automatic send(in_word_t w);
		in_data  = w;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		calls++;
		@(negedge clk);
	endtask

	task automatic gap();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		n = 0;
		if (!smooth) begin
			if (pick >= 97)
				n = $urandom_range(20, 40);
			else if (pick >= 65)
				n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// sender pause until every due word has come, plus a settle margin
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_units(int idx, int val);
		cfg_index = 2'(idx);
		cfg_data  = 4'(val);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		tot[idx] = 4'(val);
	endtask

	function automatic in_word_t random_call();
		in_word_t w;
		int r;
		w = in_word_t'($urandom);  // noise by default
		if ($urandom_range(0, 9) != 0) begin
			r = $urandom_range(0, NUM_RES - 1);
			w.res_id  = 2'(r);
			w.proc_id = 4'($urandom_range(0, 5));
			if ($urandom_range(0, 99) < 55) begin
				w.func  = FUNC_REQUEST;
				w.units = 4'($urandom_range(0, tot[r]));
			end else begin
				w.func  = FUNC_RELEASE;
				w.units = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 4));
			end
		end
		return w;
	endfunction

	// one holder takes everything, 17 more ask for one unit each (the 16th is
	// process 0 again) so the queue fills, then a big release wakes waiters
	task automatic queue_burst();
		int r;
		r = 0;
		for (int k = 0; k < NUM_RES; k++)
			if (tot[k] > tot[r])
				r = k;
		send(mk(FUNC_REQUEST, 0, r, tot[r]));
		for (int k = 1; k <= 17; k++)
			send(mk(FUNC_REQUEST, k % NUM_PROC, r, 1));
		send(mk(FUNC_RELEASE, 0, r, 15));
	endtask

	initial begin
		int settings [4][NUM_RES];
		settings = '{'{1, 2, 3, 4}, '{15, 0, 7, 15}, '{0, 15, 1, 3}, '{5, 3, 15, 2}};
		for (int r = 0; r < NUM_RES; r++)
			tot[r] = 4'(r + 1);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed calls at reset totals 1,2,3,4
		send(mk(FUNC_REQUEST, 0, 3, 4));    // grant whole resource
		send(mk(FUNC_REQUEST, 1, 3, 1));    // blocked, no free units
		send(mk(FUNC_REQUEST, 2, 3, 0));    // blocked behind queue
		send(mk(FUNC_REQUEST, 15, 3, 5));   // more than total
		send(mk(FUNC_REQUEST, 0, 3, 1));    // would exceed total held
		send(mk(FUNC_REQUEST, 3, 0, 15));
		send(mk(FUNC_RELEASE, 0, 3, 4));    // wakes both waiters
		send(mk(FUNC_RELEASE, 1, 3, 9));    // returns more than held
		send(mk(FUNC_RELEASE, 9, 2, 0));
		send(mk(FUNC_REQUEST, 15, 2, 3));
		send(mk(FUNC_RELEASE, 15, 2, 15));
		send(mk(FUNC_REQUEST, 4, 1, 2));
		send(mk(FUNC_REQUEST, 5, 1, 2));
		send(mk(FUNC_REQUEST, 5, 1, 2));    // same process queued twice
		send(mk(FUNC_RELEASE, 4, 1, 2));    // wakes only the first copy

		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0) begin
				drain();
				for (int r = 0; r < NUM_RES; r++)
					write_units(r, settings[ph][r]);
			end
			smooth = (ph == 2);
			for (int i = 0; i < PHASE_CALLS; i++) begin
				if (i == 5 && ph == 1)
					hold_asks++;
				if (i == 10 && ph > 0)
					queue_burst();
				send(random_call());
				gap();
			end
		end

		drain();
		repeat (12) @(negedge clk);
		$display("Covered %0d calls over 4 unit settings, %0d result words checked,",
			calls, words_seen);
		$display("%0d of them waiters woken from a queue.", waiters_woken);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
